/* rtl/wpa_pkg.sv */
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared constants and types for the worker pool allocator: pool size,
// derived widths, the scan token that walks the cell chain and the per-cell
// command group.
// ----------------------------------------------------------------------------
`default_nettype none

package wpa_pkg;

  // Pool size, worker 0 (the master) included; range 2..64
  localparam int NUM_WORKERS = 16;

  // Bits of a worker index; also holds any busy count (at most NUM_WORKERS-1)
  localparam int IDX_W = (NUM_WORKERS > 2) ? $clog2(NUM_WORKERS) : 1;

  // Field widths fixed by the interface
  localparam int FIELD_W = 4;

  // Common width for comparing a 4-bit field against an index or count
  localparam int CMP_W = ((IDX_W > FIELD_W) ? IDX_W : FIELD_W) + 1;

  // Peak busy count saturates here
  localparam logic [FIELD_W-1:0] PEAK_MAX = 4'd15;

  // Stream payload widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + 3 * FIELD_W);

  // Input kinds carried on tuser
  localparam logic ACT_RELEASE = 1'b0;
  localparam logic ACT_REQUEST = 1'b1;

  // Scan token passed from cell to cell, one cell per cycle
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] remaining;  // workers still wanted
    logic [FIELD_W-1:0] granted;    // workers granted so far
    logic [IDX_W-1:0]   busy_cnt;   // busy workers counted so far
  } token_t;

  // Per-cell command from the controller
  typedef struct packed {
    logic start;      // a request begins: clear grant flag
    logic free_it;    // release this worker
    logic drop_flag;  // grant flag has been reported
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/wpa_cell.sv */
// ----------------------------------------------------------------------------
// wpa_cell
// One worker slot: holds the busy bit and a "granted by this request" flag.
// Takes the scan token from its left neighbor, grabs itself if free and
// still wanted, and hands the updated token to the right in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_cell (
  input  logic               clk,
  input  logic               rst,
  input  wpa_pkg::cell_cmd_t cmd,
  input  wpa_pkg::token_t    tok_in,
  output wpa_pkg::token_t    tok_out,
  output logic               grant_flag
);
  import wpa_pkg::*;

  logic   busy;
  logic   busy_next;
  logic   grant_flag_next;
  logic   take;
  token_t tok_next;

  // Grab this worker when the token passes, it is free and more are wanted
  assign take = tok_in.valid && !busy && (tok_in.remaining != '0);

  always_comb begin
    busy_next = busy;
    if (cmd.free_it) begin
      busy_next = 1'b0;
    end else if (take) begin
      busy_next = 1'b1;
    end

    grant_flag_next = grant_flag;
    if (cmd.start || cmd.drop_flag) begin
      grant_flag_next = 1'b0;
    end
    if (take) begin
      grant_flag_next = 1'b1;
    end

    // Token update for the neighbor
    tok_next.valid     = tok_in.valid;
    tok_next.remaining = tok_in.remaining - FIELD_W'(take);
    tok_next.granted   = tok_in.granted + FIELD_W'(take);
    tok_next.busy_cnt  = tok_in.busy_cnt + IDX_W'(busy || take);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      grant_flag <= 1'b0;
      tok_out    <= '0;
    end else begin
      busy       <= busy_next;
      grant_flag <= grant_flag_next;
      tok_out    <= tok_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/wpa_ctrl.sv */
// ----------------------------------------------------------------------------
// wpa_ctrl
// Sequencer for the allocator: takes input transactions, launches the scan
// token into the cell chain, collects the totals at the tail, updates the
// peak and reports each granted worker, or a single empty result, through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wpa_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  // input stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] worker_id, [7:4] request_count
  input  logic [wpa_pkg::IN_TDATA_W-1:0]         s_axis_tdata,
  // [0] action
  input  logic                                   s_axis_tuser,
  // cell chain
  output wpa_pkg::token_t                        tok_head,
  input  wpa_pkg::token_t                        tok_tail,
  output wpa_pkg::cell_cmd_t [wpa_pkg::NUM_WORKERS-1:1] cmd,
  input  logic [wpa_pkg::NUM_WORKERS-1:1]        grant_flags,
  // output stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [0] grant_valid, [4:1] granted_worker, [8:5] grant_total,
  // [12:9] peak_busy, [15:13] zero
  output logic [wpa_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import wpa_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [FIELD_W-1:0] total;
  logic [FIELD_W-1:0] emitted;
  logic [FIELD_W-1:0] peak;

  logic               in_xfer;
  logic               is_request;
  logic               rel_ok;
  logic [FIELD_W-1:0] worker_id;
  logic [FIELD_W-1:0] request_count;
  logic               out_free;
  logic               emit_grant;
  logic [IDX_W-1:0]   low_idx;
  logic               last_grant;
  logic [FIELD_W-1:0] busy_sat;
  logic [FIELD_W-1:0] peak_next;

  assign worker_id     = s_axis_tdata[FIELD_W-1:0];
  assign request_count = s_axis_tdata[2*FIELD_W-1:FIELD_W];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_request    = (s_axis_tuser == ACT_REQUEST);

  // Master and out-of-pool ids are ignored on release
  assign rel_ok = (worker_id != '0) && (CMP_W'(worker_id) < CMP_W'(NUM_WORKERS));

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign emit_grant = (state == ST_EMIT) && out_free && (total != '0);
  assign last_grant = ((emitted + 4'd1) == total);

  // Lowest granted worker not yet reported
  always_comb begin
    low_idx = '0;
    for (int i = NUM_WORKERS - 1; i >= 1; i--) begin
      if (grant_flags[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  // Token launched into the first cell when a request is taken
  always_comb begin
    tok_head.valid     = in_xfer && is_request;
    tok_head.remaining = request_count;
    tok_head.granted   = '0;
    tok_head.busy_cnt  = '0;
  end

  // Per-cell commands
  always_comb begin
    for (int i = 1; i < NUM_WORKERS; i++) begin
      cmd[i].start     = in_xfer && is_request;
      cmd[i].free_it   = in_xfer && !is_request && rel_ok &&
                         (CMP_W'(worker_id) == CMP_W'(i));
      cmd[i].drop_flag = emit_grant && (low_idx == IDX_W'(i));
    end
  end

  // Saturated busy count and new peak from the token at the tail
  always_comb begin
    if (CMP_W'(tok_tail.busy_cnt) > CMP_W'(PEAK_MAX)) begin
      busy_sat = PEAK_MAX;
    end else begin
      busy_sat = FIELD_W'(tok_tail.busy_cnt);
    end
    peak_next = (busy_sat > peak) ? busy_sat : peak;
  end

  // State, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      total         <= '0;
      emitted       <= '0;
      peak          <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tlast  <= 1'b0;
    end else begin
      // Output valid: set on each emitted result, cleared once taken
      if ((state == ST_EMIT) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && is_request) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok_tail.valid) begin
            total   <= tok_tail.granted;
            peak    <= peak_next;
            emitted <= '0;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (total == '0) begin
              // nothing granted: a single empty result
              m_axis_tdata <= {OUT_PAD_W'(0), peak, FIELD_W'(0), FIELD_W'(0), 1'b0};
              m_axis_tlast <= 1'b1;
              state        <= ST_IDLE;
            end else begin
              m_axis_tdata <= {OUT_PAD_W'(0), peak, total, FIELD_W'(low_idx), 1'b1};
              m_axis_tlast <= last_grant;
              emitted      <= emitted + 4'd1;
              if (last_grant) begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/worker_pool_allocator.sv */
// ----------------------------------------------------------------------------
// worker_pool_allocator
// Lowest-first allocator for a pool of workers, built as a chain of worker
// cells with a scan token and a small sequencer.
// ----------------------------------------------------------------------------
// A release transaction (tuser 0) frees one worker and gives no result. A
// request transaction (tuser 1) sends a token down the chain of
// NUM_WORKERS-1 cells, one cell per cycle; when it reaches the tail the
// totals and peak are registered and the results follow at one per cycle
// while the output is not stalled, one per granted worker or a single empty
// result, the last one marked by tlast. Input is accepted only between
// requests; the last result may still wait in the output register while
// the next transaction is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module worker_pool_allocator (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] worker_id, [7:4] request_count
  input  logic [wpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] action
  input  logic                            s_axis_tuser,
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] grant_valid, [4:1] granted_worker, [8:5] grant_total,
  // [12:9] peak_busy, [15:13] zero
  output logic [wpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import wpa_pkg::*;

  token_t                        tok [NUM_WORKERS];
  cell_cmd_t [NUM_WORKERS-1:1]   cmd;
  logic [NUM_WORKERS-1:1]        grant_flags;

  // Sequencer and output register
  wpa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .tok_head      (tok[0]),
    .tok_tail      (tok[NUM_WORKERS-1]),
    .cmd           (cmd),
    .grant_flags   (grant_flags),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Chain of worker cells, worker 1 first
  for (genvar i = 1; i < NUM_WORKERS; i++) begin : g_cell
    wpa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd[i]),
      .tok_in     (tok[i-1]),
      .tok_out    (tok[i]),
      .grant_flag (grant_flags[i])
    );
  end

endmodule

`default_nettype wire

/* sim/tb_worker_pool_allocator.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_worker_pool_allocator
// Self-checking bench for the worker pool allocator. A scoreboard class keeps
// its own busy map and peak count, predicts the grants of every accepted
// request and checks each output transaction in order. The run has a
// directed opening and then three random phases with different back-pressure.
// ----------------------------------------------------------------------------

module tb_worker_pool_allocator;
  import wpa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES = 2 * NUM_WORKERS + 8;

  // One expected output transaction
  typedef struct {
    logic       grant_valid;
    logic [3:0] worker;
    logic [3:0] total;
    logic [3:0] peak;
    logic       last;
  } grant_t;

  // Predicts grants from its own copy of the pool state and checks results
  class alloc_scoreboard;
    logic [NUM_WORKERS-1:0] busy_map;
    logic [3:0]             peak_busy;
    grant_t                 pending_grants[$];
    int                     errors;

    function new();
      busy_map = '0;
      peak_busy = '0;
      errors = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // Accepted input transaction: update the pool and queue the grants
    function void apply_item(input logic act, input logic [3:0] wid,
                             input logic [3:0] want);
      int     picks[$];
      int     n_busy;
      int     i;
      grant_t g;
      if (act == ACT_RELEASE) begin
        // master and absent workers are ignored; a free worker stays free
        if (wid != 4'd0 && int'(wid) < NUM_WORKERS)
          busy_map[wid] = 1'b0;
        return;
      end
      for (i = 1; i < NUM_WORKERS && picks.size() < int'(want); i++) begin
        if (!busy_map[i]) begin
          busy_map[i] = 1'b1;
          picks.push_back(i);
        end
      end
      n_busy = $countones(busy_map[NUM_WORKERS-1:1]);
      if (n_busy > 15) n_busy = 15;
      if (n_busy > int'(peak_busy)) peak_busy = 4'(n_busy);
      if (picks.size() == 0) begin
        g.grant_valid = 1'b0;
        g.worker = 4'd0;
        g.total = 4'd0;
        g.peak = peak_busy;
        g.last = 1'b1;
        pending_grants.push_back(g);
        return;
      end
      for (i = 0; i < picks.size(); i++) begin
        g.grant_valid = 1'b1;
        g.worker = 4'(picks[i]);
        g.total = 4'(picks.size());
        g.peak = peak_busy;
        g.last = (i == picks.size() - 1);
        pending_grants.push_back(g);
      end
    endfunction

    // Accepted output transaction: compare with the oldest expectation
    task check_grant(input logic [OUT_TDATA_W-1:0] data, input logic tlast);
      grant_t g;
      if (pending_grants.size() == 0) begin
        flag_mismatch($sformatf("unexpected result tdata=%h tlast=%b", data, tlast));
        return;
      end
      g = pending_grants.pop_front();
      if (data[0] !== g.grant_valid)
        flag_mismatch($sformatf("grant_valid %b, expected %b", data[0], g.grant_valid));
      if (data[4:1] !== g.worker)
        flag_mismatch($sformatf("granted_worker %0d, expected %0d", data[4:1], g.worker));
      if (data[8:5] !== g.total)
        flag_mismatch($sformatf("grant_total %0d, expected %0d", data[8:5], g.total));
      if (data[12:9] !== g.peak)
        flag_mismatch($sformatf("peak_busy %0d, expected %0d", data[12:9], g.peak));
      if (tlast !== g.last)
        flag_mismatch($sformatf("tlast %b, expected %b", tlast, g.last));
      if (data[OUT_TDATA_W-1:13] !== '0)
        flag_mismatch($sformatf("pad bits %b not zero", data[OUT_TDATA_W-1:13]));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  alloc_scoreboard sb;
  int src_idle_pct;
  int sink_idle_pct;
  int cycle_count;

  worker_pool_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("worker_pool_allocator regression: fail");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // monitor both streams
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_grant(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready)
        sb.apply_item(s_axis_tuser, s_axis_tdata[3:0], s_axis_tdata[7:4]);
    end
  end

  // Offer one input transaction and hold it until accepted
  task automatic send_item(input logic act, input logic [3:0] wid,
                           input logic [3:0] cnt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {cnt, wid};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Hold off the sender until every predicted grant has come out;
  // first lets the monitor log the last accepted item
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    logic       act;
    logic [3:0] wid;
    logic [3:0] cnt;
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(0, 99) < 40) ? ACT_REQUEST : ACT_RELEASE;
      wid = 4'($urandom_range(0, 15));
      // mostly small requests so the pool churns instead of staying full
      if (act == ACT_REQUEST && $urandom_range(0, 1) == 0)
        cnt = 4'($urandom_range(1, 4));
      else
        cnt = 4'($urandom_range(0, 15));
      send_item(act, wid, cnt);
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = ACT_RELEASE;
    s_axis_tdata = '0;
    src_idle_pct = 0;
    sink_idle_pct = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty request, master release, fill, overflow, re-release
    src_idle_pct = 38;
    sink_idle_pct = 60;
    send_item(ACT_REQUEST, 4'd9,  4'd0);
    send_item(ACT_RELEASE, 4'd0,  4'd15);
    send_item(ACT_REQUEST, 4'd15, 4'd1);
    send_item(ACT_REQUEST, 4'd0,  4'd15);
    send_item(ACT_REQUEST, 4'd5,  4'd3);
    send_item(ACT_RELEASE, 4'd15, 4'd0);
    send_item(ACT_RELEASE, 4'd15, 4'd6);
    send_item(ACT_RELEASE, 4'd7,  4'd0);
    send_item(ACT_REQUEST, 4'd0,  4'd15);
    send_item(ACT_RELEASE, 4'd1,  4'd0);
    send_item(ACT_RELEASE, 4'd2,  4'd0);
    send_item(ACT_RELEASE, 4'd8,  4'd0);
    send_item(ACT_RELEASE, 4'd8,  4'd0);
    send_item(ACT_REQUEST, 4'd10, 4'd4);
    send_item(ACT_REQUEST, 4'd3,  4'd2);
    for (int w = 0; w < 16; w++)
      send_item(ACT_RELEASE, 4'(w), 4'($urandom_range(0, 15)));
    send_item(ACT_REQUEST, 4'd0,  4'd8);
    wait_drained();

    // random phases with different back-pressure
    src_idle_pct = 38;
    sink_idle_pct = 60;
    send_random(ITEMS_PER_PHASE);
    wait_drained();

    src_idle_pct = 60;
    sink_idle_pct = 38;
    send_random(ITEMS_PER_PHASE);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    send_random(ITEMS_PER_PHASE);

    // drain, then give any stray result time to show up
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending_grants.size() == 0)
      $display("worker_pool_allocator regression: pass");
    else
      $display("worker_pool_allocator regression: fail");
    $finish;
  end

endmodule

/* sim.f */
rtl/wpa_pkg.sv
rtl/wpa_cell.sv
rtl/wpa_ctrl.sv
rtl/worker_pool_allocator.sv
sim/tb_worker_pool_allocator.sv
